>>> hw/rtl/ifkc_pkg.sv
// Package for the idle-framed keyword classifier.
// Item types, opcodes, keyword table and sizing constants. No dependencies.
`timescale 1ns / 1ps

package ifkc_pkg;

    localparam int BUFFER_BYTES = 128;
    localparam int WINDOW_BYTES = 9;
    localparam int CNT_W        = 8;
    localparam int TICK_W       = 17;
    localparam int WORD_COUNT   = 21;
    localparam int STATUS_WORDS = 14;
    localparam int MAX_WORD_LEN = 9;
    localparam int WORD_BITS    = 8 * MAX_WORD_LEN;

    localparam logic [TICK_W-1:0] IDLE_TICKS_RESET = TICK_W'(100);

    typedef enum logic [1:0]
    {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_SERVICE = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    localparam logic [4:0] STATUS_CHANNEL = 5'd5;

    typedef struct packed
    {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [4:0] channel_index;
    } item_t;

    typedef struct packed
    {
        logic [3:0] status_code;
        logic       status_written;
        logic       reading_ready;
        logic [4:0] reading_slot;
        logic       frame_done;
    } result_t;

    // Frame update controls from top to the window chain.
    typedef struct packed
    {
        logic       byte_en;
        logic [7:0] data_byte;
        logic       clear;
    } frame_ctrl_t;

    // Text right-aligned: byte i matches the i-th newest window byte.
    localparam logic [WORD_BITS-1:0] WORD_TEXT [WORD_COUNT] = '{
        WORD_BITS'("INIT"),     WORD_BITS'("START"),   WORD_BITS'("MEAS"),
        WORD_BITS'("CAL"),      WORD_BITS'("ERROR"),   WORD_BITS'("ADJUST"),
        WORD_BITS'("STANDBY"),  WORD_BITS'("OVERRANGE"), WORD_BITS'("ACCL"),
        WORD_BITS'("CALEXT"),   WORD_BITS'("CALINT"),  WORD_BITS'("PROOF"),
        WORD_BITS'("PURGE"),    WORD_BITS'("SLEEP"),   WORD_BITS'("g/a"),
        WORD_BITS'("mbar*l/s"), WORD_BITS'("ppm"),     WORD_BITS'("oz/yr"),
        WORD_BITS'("Torr*l/s"), WORD_BITS'("Pa*m3/s"), WORD_BITS'("atm*cc/s")
    };

    localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd4, 4'd6, 4'd6,
        4'd5, 4'd5, 4'd5, 4'd3, 4'd8, 4'd3, 4'd5, 4'd8, 4'd7, 4'd8
    };

endpackage

>>> hw/rtl/ifkc_cell.sv
// One byte stage of the sliding window chain.
// Imports ifkc_pkg but uses nothing from it; loads from its neighbor.
`timescale 1ns / 1ps

module ifkc_cell
    import ifkc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       shift,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = '0;
        end
        else if (shift)
        begin
            byte_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

>>> hw/rtl/ifkc_frame.sv
// Frame store: window chain of ifkc_cell, seen-word flags, length and count.
// Depends on ifkc_pkg and ifkc_cell.
`timescale 1ns / 1ps

module ifkc_frame
    import ifkc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  frame_ctrl_t           ctrl,
    output logic [WORD_COUNT-1:0] counted
);

    logic [7:0]            win_q   [WINDOW_BYTES];
    logic [7:0]            win_new [WINDOW_BYTES];
    logic [WORD_COUNT-1:0] hit;
    logic [WORD_COUNT-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      count_inc;
    logic                  term_reg, term_next;
    logic                  chain_clear;
    logic                  chain_shift;

    assign win_new[0] = ctrl.data_byte;

    genvar g;
    generate
        for (g = 0; g < WINDOW_BYTES; g++)
        begin : g_cell
            if (g > 0)
            begin : g_link
                assign win_new[g] = win_q[g-1];
            end
            ifkc_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .clear (chain_clear),
                .shift (chain_shift),
                .d     (win_new[g]),
                .q     (win_q[g])
            );
        end
    endgenerate

    // Suffix match on the window as it stands after the shift.
    always_comb
    begin
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            hit[w] = (int'(WORD_LEN[w]) <= WINDOW_BYTES);
            for (int i = 0; i < MAX_WORD_LEN; i++)
            begin
                if (i < int'(WORD_LEN[w]) && i < WINDOW_BYTES)
                begin
                    if (win_new[i] != WORD_TEXT[w][8*i +: 8])
                    begin
                        hit[w] = 1'b0;
                    end
                end
            end
        end
    end

    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        seen_next   = seen_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        term_next   = term_reg;
        chain_clear = 1'b0;
        chain_shift = 1'b0;
        if (ctrl.clear)
        begin
            seen_next   = '0;
            len_next    = '0;
            count_next  = '0;
            term_next   = 1'b0;
            chain_clear = 1'b1;
        end
        else if (ctrl.byte_en)
        begin
            if (count_inc >= CNT_W'(BUFFER_BYTES))
            begin
                seen_next   = '0;
                len_next    = '0;
                count_next  = '0;
                term_next   = 1'b0;
                chain_clear = 1'b1;
            end
            else
            begin
                count_next = count_inc;
                if (!term_reg)
                begin
                    if (ctrl.data_byte == 8'd0)
                    begin
                        term_next = 1'b1;
                    end
                    else
                    begin
                        chain_shift = 1'b1;
                        len_next    = len_reg + CNT_W'(1);
                        seen_next   = seen_reg | hit;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            term_reg  <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            counted[w] = seen_reg[w] && (len_reg > CNT_W'(WORD_LEN[w]));
        end
    end

endmodule

>>> hw/rtl/idle_framed_keyword_classifier.sv
// Top level: idle timer, service decode, result register.
// Depends on ifkc_pkg and ifkc_frame.
//
//  channel   handshake                  payload
//  item      item_valid / item_ready    item   (item_t)
//  result    result_valid / result_ready result (result_t)
//  config    cfg_we                     cfg_data (idle_ticks)
//
// One item per cycle while item_ready is high; each item yields one registered result in the next cycle.
// Window match and priority pick are combinational, fed by the 9-cell chain.
// item_ready drops only while a result is held and result_ready is low.
// rst_n clears all state but the result register; idle_ticks resets to 100.
`timescale 1ns / 1ps

module idle_framed_keyword_classifier
    import ifkc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [TICK_W-1:0] cfg_data
);

    logic [TICK_W-1:0]     idle_ticks_reg;
    logic [TICK_W-1:0]     idle_count_reg, idle_count_next;
    logic [TICK_W-1:0]     idle_inc;
    logic                  timer_running_reg, timer_running_next;
    logic                  frame_complete_reg, frame_complete_next;
    logic [3:0]            run_status_reg, run_status_next;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg, result_next;
    logic                  accept;
    logic [WORD_COUNT-1:0] counted;
    logic [3:0]            pick;
    logic                  unit_hit;
    frame_ctrl_t           fctrl;
    opcode_t               op;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;
    assign op         = opcode_t'(item.opcode);

    assign fctrl.byte_en   = accept && (op == OP_BYTE);
    assign fctrl.data_byte = item.data_byte;
    assign fctrl.clear     = accept && (op == OP_SERVICE);

    ifkc_frame u_frame
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (fctrl),
        .counted (counted)
    );

    always_comb
    begin
        pick = '0;
        for (int w = STATUS_WORDS - 1; w >= 0; w--)
        begin
            if (counted[w])
            begin
                pick = 4'(w + 1);
            end
        end
    end

    assign unit_hit = |counted[WORD_COUNT-1:STATUS_WORDS];
    assign idle_inc = idle_count_reg + TICK_W'(1);

    always_comb
    begin
        idle_count_next     = idle_count_reg;
        timer_running_next  = timer_running_reg;
        frame_complete_next = frame_complete_reg;
        run_status_next     = run_status_reg;
        result_valid_next   = result_valid_reg;
        result_next         = result_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (accept)
        begin
            result_next.status_written = 1'b0;
            result_next.reading_ready  = 1'b0;
            result_next.reading_slot   = '0;
            case (op)
                OP_BYTE:
                begin
                    idle_count_next    = '0;
                    timer_running_next = 1'b1;
                end
                OP_TICK:
                begin
                    if (timer_running_reg)
                    begin
                        idle_count_next = idle_inc;
                        if (idle_inc >= idle_ticks_reg)
                        begin
                            timer_running_next  = 1'b0;
                            idle_count_next     = '0;
                            frame_complete_next = 1'b1;
                        end
                    end
                end
                OP_SERVICE:
                begin
                    if (frame_complete_reg)
                    begin
                        if (item.channel_index == STATUS_CHANNEL)
                        begin
                            run_status_next            = pick;
                            result_next.status_written = 1'b1;
                        end
                        if (unit_hit)
                        begin
                            result_next.reading_ready = 1'b1;
                            result_next.reading_slot  =
                                {item.channel_index[3:0] - 4'd1, 1'b0};
                        end
                    end
                    frame_complete_next = 1'b0;
                end
                default:
                begin
                end
            endcase
            result_next.status_code = run_status_next;
            result_next.frame_done  = frame_complete_next;
            result_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg     <= IDLE_TICKS_RESET;
            idle_count_reg     <= '0;
            timer_running_reg  <= 1'b0;
            frame_complete_reg <= 1'b0;
            run_status_reg     <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                idle_ticks_reg <= cfg_data;
            end
            idle_count_reg     <= idle_count_next;
            timer_running_reg  <= timer_running_next;
            frame_complete_reg <= frame_complete_next;
            run_status_reg     <= run_status_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg
    ) else $error("accepted item produced no result");

    a_written_clears_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.status_written |-> !result_reg.frame_done
    ) else $error("status written but frame still done");

    a_slot_zero_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.reading_ready |-> result_reg.reading_slot == '0
    ) else $error("reading slot set without reading");

    a_stopped_timer_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        !timer_running_reg |-> idle_count_reg == '0
    ) else $error("idle count nonzero with timer stopped");

endmodule
